// ----- sv/sdc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants of the scaled decimal comparator
// Item layouts, relation codes and datapath widths.
// ----------------------------------------------------------------------------
package sdc_pkg;

   // datapath widths
   localparam int MANT_W         = 96;
   localparam int MAG_W          = 192;
   localparam int SCALE_W        = 5;
   localparam int CMD_W          = 3;
   localparam int MAX_SCALE_DEF  = 28;

   // relation codes
   localparam logic [CMD_W-1:0] CMD_LT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EQ     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_NE     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_ABS_GE = 3'd6;

   // one input item
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [63:0]        a_mant_lo;
      logic [31:0]        a_mant_hi;
      logic [SCALE_W-1:0] a_scale;
      logic               a_negative;
      logic [63:0]        b_mant_lo;
      logic [31:0]        b_mant_hi;
      logic [SCALE_W-1:0] b_scale;
      logic               b_negative;
   } req_type;

   // one result item
   typedef struct packed {
      logic holds;
   } rsp_type;

endpackage

// ----- sv/sdc_req_if.sv -----
// ----------------------------------------------------------------------------
// sdc_req_if: request channel of the scaled decimal comparator
// Valid/ready handshake carrying one comparison item.
// ----------------------------------------------------------------------------
interface sdc_req_if;
   import sdc_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/sdc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sdc_rsp_if: response channel of the scaled decimal comparator
// Valid/ready handshake carrying one truth bit.
// ----------------------------------------------------------------------------
interface sdc_rsp_if;
   import sdc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/scaled_decimal_compare.sv -----
// ----------------------------------------------------------------------------
// scaled_decimal_compare: signed decimal comparator with scale alignment
// Aligns two 96-bit decimal mantissas by repeated multiply-by-ten, then
// evaluates the requested relation as a signed magnitude compare (magnitude only for CMD_ABS_GE).
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one comparison item (relation code, two mantissas, scales
//   and signs); rsp_ch returns one item with the truth bit holds for each.
//   A scale above MAX_SCALE is treated as MAX_SCALE; +0 and -0 are equal;
//   relation code 7 gives holds = 0.
// Timing:
//   one item is accepted, then the operand with the smaller scale goes
//   through a single shared 192-bit times-ten adder once per cycle, d times
//   where d is the scale difference (scaling state), followed by the 192-bit
//   compare in the compare state, which loads the result into the output
//   register. req_ch.ready is low from acceptance until the result is
//   loaded into the output register.
// Reset and stalls:
//   synchronous reset empties the block and the output register. While
//   rsp_ch.ready is low the result waits in the output register and a new
//   item is still taken and worked on; it then waits in the compare step
//   until the output register is free.
// ----------------------------------------------------------------------------
module scaled_decimal_compare #(
   parameter int MAX_SCALE = sdc_pkg::MAX_SCALE_DEF
) (
   input logic       clock,
   input logic       reset,
   sdc_req_if.sink   req_ch,
   sdc_rsp_if.source rsp_ch
);
   import sdc_pkg::*;

   localparam int                 CNT_W       = (MAX_SCALE < 2) ? 1 : $clog2(MAX_SCALE + 1);
   localparam logic [SCALE_W-1:0] MAX_SCALE_L = SCALE_W'(MAX_SCALE);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              holds_ff, holds_in;
   logic [MAG_W-1:0]  ma_ff, ma_in;
   logic [MAG_W-1:0]  mb_ff, mb_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              mul_a_ff, mul_a_in;
   logic              na_ff, na_in;
   logic              nb_ff, nb_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;

   logic               req_acc;
   logic               out_free;
   logic [SCALE_W-1:0] sa_sat, sb_sat, sdiff;
   logic [MANT_W-1:0]  a_mant, b_mant;
   logic [MAG_W-1:0]   unit_src, unit_res;
   logic               mag_gt, mag_eq, sgn_lt, sgn_eq, sgn_gt;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // scale saturation and alignment distance
   always_comb begin
      sa_sat = (req_ch.data.a_scale > MAX_SCALE_L) ? MAX_SCALE_L : req_ch.data.a_scale;
      sb_sat = (req_ch.data.b_scale > MAX_SCALE_L) ? MAX_SCALE_L : req_ch.data.b_scale;
      sdiff  = (sa_sat < sb_sat) ? (sb_sat - sa_sat) : (sa_sat - sb_sat);
      a_mant = {req_ch.data.a_mant_hi, req_ch.data.a_mant_lo};
      b_mant = {req_ch.data.b_mant_hi, req_ch.data.b_mant_lo};
   end

   // shared times-ten unit: x*8 + x*2
   assign unit_src = mul_a_ff ? ma_ff : mb_ff;
   assign unit_res = {unit_src[MAG_W-4:0], 3'b000} + {unit_src[MAG_W-2:0], 1'b0};

   // magnitude and signed compare
   always_comb begin
      mag_gt = ma_ff > mb_ff;
      mag_eq = ma_ff == mb_ff;
      if (na_ff != nb_ff) begin
         sgn_lt = na_ff;
         sgn_gt = nb_ff;
         sgn_eq = 1'b0;
      end else begin
         sgn_eq = mag_eq;
         sgn_gt = na_ff ? (!mag_gt && !mag_eq) : mag_gt;
         sgn_lt = !sgn_gt && !mag_eq;
      end
   end

   // relation select
   always_comb begin
      case (cmd_ff)
         CMD_LT:     holds_in = sgn_lt;
         CMD_LE:     holds_in = sgn_lt || sgn_eq;
         CMD_GT:     holds_in = sgn_gt;
         CMD_GE:     holds_in = sgn_gt || sgn_eq;
         CMD_EQ:     holds_in = sgn_eq;
         CMD_NE:     holds_in = !sgn_eq;
         CMD_ABS_GE: holds_in = mag_gt || mag_eq;
         default:    holds_in = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      cnt_in       = cnt_ff;
      mul_a_in     = mul_a_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      cmd_in       = cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ma_in    = {{(MAG_W-MANT_W){1'b0}}, a_mant};
               mb_in    = {{(MAG_W-MANT_W){1'b0}}, b_mant};
               cnt_in   = CNT_W'(sdiff);
               mul_a_in = sa_sat < sb_sat;
               na_in    = req_ch.data.a_negative && (a_mant != '0);
               nb_in    = req_ch.data.b_negative && (b_mant != '0);
               cmd_in   = req_ch.data.cmd;
               state_in = (sdiff != '0) ? ST_SCALE : ST_CMP;
            end
         end
         ST_SCALE: begin
            if (mul_a_ff) begin
               ma_in = unit_res;
            end else begin
               mb_in = unit_res;
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      cnt_ff   <= cnt_in;
      mul_a_ff <= mul_a_in;
      na_ff    <= na_in;
      nb_ff    <= nb_in;
      cmd_ff   <= cmd_in;
      if (state_ff == ST_CMP && out_free) begin
         holds_ff <= holds_in;
      end
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.data.holds = holds_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ST_IDLE)
      else $error("block idle right after taking an item");

   a_scale_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE |-> cnt_ff != '0)
      else $error("scaling step with an exhausted count");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("compare step did not deliver its item");

   a_zero_is_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && na_ff) |-> ma_ff != '0)
      else $error("negative sign kept on a zero mantissa");
endmodule
